### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted (active low)
`define R5_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is asserted (active low)
`define R5_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/core/r5brr_pkg.sv
// Shared types and constants of the RAID5 block read with rebuild core.
// Depends on nothing; used by the core and its checker.
package r5brr_pkg;

    localparam int CMD_W      = 1;
    localparam int DISK_IDX_W = 3;
    localparam int WORD_OFF_W = 12;
    localparam int DATA_W     = 32;
    localparam int BLOCK_W    = 32;
    localparam int N_W        = 4;
    localparam int S_W        = 13;
    localparam int WPD_W      = 13;
    localparam int MASK_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISK_COUNT     = 2'd0,
        CFG_STRIPE_WORDS   = 2'd1,
        CFG_WORDS_PER_DISK = 2'd2,
        CFG_PRESENT_MASK   = 2'd3
    } t_cfg_idx;

endpackage

### rtl/core/r5brr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module r5brr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/raid5_block_read_with_rebuild_core.sv
// RAID5 block read with single-disk rebuild, left-symmetric parity rotation.
// Depends on r5brr_pkg and r5brr_ram.
//
//  channel   handshake              payload
//  --------  ---------------------  ---------------------------------------------
//  command   start / busy           i_command i_disk_index i_word_offset
//                                   i_word_data i_block_number
//  result    o_valid (1-cycle)      o_read_data o_available
//  config    i_cfg_valid/o_cfg_ready i_cfg_index i_cfg_data
//
// A load is written into the disk store at acceptance; busy stays low.
// A query out of range or under a bad configuration strobes its result the next cycle.
// Any other query holds busy through three passes of the shared one-bit-per-cycle divider, then
// map and check, plus, when it reads, a scan of all n disks through the disk store and a drain.
// The result strobes in the first cycle busy is low.
// Configuration is taken only while idle. Reset is synchronous; the disk store is not cleared.
module raid5_block_read_with_rebuild_core #(
    parameter int MAX_DISKS = 8,
    parameter int MAX_WORDS = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [r5brr_pkg::CMD_W-1:0]         i_command,
    input  logic [r5brr_pkg::DISK_IDX_W-1:0]    i_disk_index,
    input  logic [r5brr_pkg::WORD_OFF_W-1:0]    i_word_offset,
    input  logic [r5brr_pkg::DATA_W-1:0]        i_word_data,
    input  logic [r5brr_pkg::BLOCK_W-1:0]       i_block_number,
    output logic                                o_valid,
    output logic [r5brr_pkg::DATA_W-1:0]        o_read_data,
    output logic                                o_available,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [r5brr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [r5brr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int DEPTH     = MAX_DISKS * MAX_WORDS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int NMAX      = (MAX_DISKS < 15) ? MAX_DISKS : 15;
    localparam int CAP       = (NMAX - 1) * MAX_WORDS;
    localparam int DIV_W_RAW = $clog2(CAP);
    localparam int DIV_W     = (DIV_W_RAW < 2) ? 2 : DIV_W_RAW;
    localparam int CNT_W     = $clog2(DIV_W + 1);
    localparam int PROD_W    = DIV_W + r5brr_pkg::S_W;
    localparam int N_W       = r5brr_pkg::N_W;
    localparam int S_W       = r5brr_pkg::S_W;
    localparam int CAP_W     = N_W + r5brr_pkg::WPD_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV1,
        ST_DIV2,
        ST_DIV3,
        ST_MAP,
        ST_CHECK,
        ST_READ,
        ST_DRAIN
    } t_state;

    t_state                              r_state;
    logic [N_W-1:0]                      r_n;
    logic [S_W-1:0]                      r_s;
    logic [r5brr_pkg::WPD_W-1:0]         r_wpd;
    logic [r5brr_pkg::MASK_W-1:0]        r_mask;

    logic [DIV_W-1:0]                    r_quo;
    logic [S_W-1:0]                      r_rem;
    logic [S_W-1:0]                      r_dvs;
    logic [CNT_W-1:0]                    r_cnt;
    logic [S_W-1:0]                      r_rem1;
    logic [N_W-1:0]                      r_rem2;
    logic [N_W-1:0]                      r_rowmod;
    logic [DIV_W-1:0]                    r_row;
    logic [N_W-1:0]                      r_disk;
    logic [PROD_W-1:0]                   r_pos;
    logic                                r_direct;
    logic [N_W-1:0]                      r_l;
    logic                                r_pend;
    logic [r5brr_pkg::DATA_W-1:0]        r_acc;
    logic                                r_out_valid;
    logic [r5brr_pkg::DATA_W-1:0]        r_out_data;
    logic                                r_out_avail;

    logic [S_W:0]                        div_t;
    logic                                div_ge;
    logic [S_W-1:0]                      n_rem;
    logic [DIV_W-1:0]                    n_quo;
    logic                                div_last;

    logic                                cfg_ok;
    logic [CAP_W-1:0]                    cap;
    logic                                in_range;
    logic [r5brr_pkg::MASK_W-1:0]        mask_n;
    logic [N_W-1:0]                      ones;
    logic [N_W-1:0]                      parity;
    logic [N_W:0]                        dsum;
    logic [N_W:0]                        dmod;
    logic                                pos_ok;
    logic                                present;
    logic                                rebuild;
    logic                                issue;

    logic                                accept;
    logic                                load_we;
    logic [ADDR_W-1:0]                   waddr;
    logic [ADDR_W-1:0]                   raddr;
    logic [r5brr_pkg::DATA_W-1:0]        rdata;

    assign accept = start && !busy;

    assign o_cfg_ready = !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n    <= N_W'(2);
            r_s    <= S_W'(1);
            r_wpd  <= r5brr_pkg::WPD_W'(1);
            r_mask <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (r5brr_pkg::t_cfg_idx'(i_cfg_index))
                r5brr_pkg::CFG_DISK_COUNT:     r_n    <= i_cfg_data[N_W-1:0];
                r5brr_pkg::CFG_STRIPE_WORDS:   r_s    <= i_cfg_data[S_W-1:0];
                r5brr_pkg::CFG_WORDS_PER_DISK: r_wpd  <= i_cfg_data[r5brr_pkg::WPD_W-1:0];
                r5brr_pkg::CFG_PRESENT_MASK:   r_mask <= i_cfg_data[r5brr_pkg::MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg_ok = (r_n >= N_W'(2)) && (32'(r_n) <= 32'(MAX_DISKS)) && (r_s != '0)
                 && (r_wpd != '0) && (32'(r_wpd) <= 32'(MAX_WORDS));
        cap      = CAP_W'(r_n - N_W'(1)) * CAP_W'(r_wpd);
        in_range = i_block_number < r5brr_pkg::BLOCK_W'(cap);

        div_t    = {r_rem, r_quo[DIV_W-1]};
        div_ge   = div_t >= {1'b0, r_dvs};
        n_rem    = div_ge ? S_W'(div_t - {1'b0, r_dvs}) : div_t[S_W-1:0];
        n_quo    = {r_quo[DIV_W-2:0], div_ge};
        div_last = r_cnt == CNT_W'(DIV_W - 1);

        ones = '0;
        for (int d = 0; d < r5brr_pkg::MASK_W; d++) begin
            mask_n[d] = r_mask[d] && (N_W'(d) < r_n);
            ones      = ones + N_W'(mask_n[d]);
        end

        parity  = r_n - N_W'(1) - r_rowmod;
        dsum    = (N_W + 1)'(parity) + (N_W + 1)'(1) + (N_W + 1)'(r_rem2);
        dmod    = (dsum >= (N_W + 1)'(r_n)) ? dsum - (N_W + 1)'(r_n) : dsum;

        pos_ok  = r_pos < PROD_W'(r_wpd);
        present = (32'(r_disk) < 32'(r5brr_pkg::MASK_W)) && mask_n[r_disk[2:0]];
        rebuild = ones == (r_n - N_W'(1));
        issue   = (r_state == ST_READ) && (r_direct ? (r_l == r_disk) : (r_l != r_disk));

        load_we = accept && (i_command == r5brr_pkg::CMD_LOAD)
                  && (32'(i_disk_index) < 32'(MAX_DISKS))
                  && (32'(i_word_offset) < 32'(MAX_WORDS));
        waddr   = ADDR_W'(i_disk_index) * ADDR_W'(MAX_WORDS) + ADDR_W'(i_word_offset);
        raddr   = ADDR_W'(r_l) * ADDR_W'(MAX_WORDS) + ADDR_W'(r_pos);
    end

    r5brr_ram #(
        .WIDTH(r5brr_pkg::DATA_W),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (load_we),
        .i_waddr(waddr),
        .i_wdata(i_word_data),
        .i_re   (issue),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept && (i_command == r5brr_pkg::CMD_QUERY)) begin
                        if (cfg_ok && in_range) begin
                            r_quo   <= i_block_number[DIV_W-1:0];
                            r_rem   <= '0;
                            r_dvs   <= r_s;
                            r_cnt   <= '0;
                            r_state <= ST_DIV1;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_out_data  <= '0;
                            r_out_avail <= 1'b0;
                        end
                    end
                end
                ST_DIV1, ST_DIV2, ST_DIV3: begin
                    r_quo <= n_quo;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (div_last) begin
                        r_rem <= '0;
                        r_cnt <= '0;
                        case (r_state)
                            ST_DIV1: begin
                                r_rem1  <= n_rem;
                                r_dvs   <= S_W'(r_n - N_W'(1));
                                r_state <= ST_DIV2;
                            end
                            ST_DIV2: begin
                                r_rem2  <= n_rem[N_W-1:0];
                                r_row   <= n_quo;
                                r_dvs   <= S_W'(r_n);
                                r_state <= ST_DIV3;
                            end
                            default: begin
                                r_rowmod <= n_rem[N_W-1:0];
                                r_state  <= ST_MAP;
                            end
                        endcase
                    end
                end
                ST_MAP: begin
                    r_disk  <= dmod[N_W-1:0];
                    r_pos   <= PROD_W'(r_row) * PROD_W'(r_s) + PROD_W'(r_rem1);
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (!pos_ok || (!present && !rebuild)) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= '0;
                        r_out_avail <= 1'b0;
                        r_state     <= ST_IDLE;
                    end else begin
                        r_direct <= present;
                        r_l      <= '0;
                        r_acc    <= '0;
                        r_pend   <= 1'b0;
                        r_state  <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (r_pend) begin
                        r_acc <= r_acc ^ rdata;
                    end
                    r_pend <= issue;
                    r_l    <= r_l + N_W'(1);
                    if (r_l == r_n - N_W'(1)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_out_valid <= 1'b1;
                    r_out_data  <= r_pend ? (r_acc ^ rdata) : r_acc;
                    r_out_avail <= 1'b1;
                    r_pend      <= 1'b0;
                    r_state     <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy        = r_state != ST_IDLE;
    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_available = r_out_avail;

endmodule

### rtl/core/r5brr_checker.sv
// Port-level checker of the RAID5 block read core, bound to the core module.
// Depends on r5brr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module r5brr_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic [r5brr_pkg::CMD_W-1:0]    i_command,
    input logic                           o_valid,
    input logic [r5brr_pkg::DATA_W-1:0]   o_read_data,
    input logic                           o_available
);

    logic acc_load;
    logic acc_query;

    assign acc_load  = start && !busy && (i_command == r5brr_pkg::CMD_LOAD);
    assign acc_query = start && !busy && (i_command == r5brr_pkg::CMD_QUERY);

    `R5_ASSERT_NXT(a_load_no_result, i_clk, i_rst_n, acc_load, !o_valid)
    `R5_ASSERT_IMP(a_result_when_idle, i_clk, i_rst_n, o_valid, !busy)
    `R5_ASSERT_IMP(a_unavail_zero, i_clk, i_rst_n, o_valid && !o_available, o_read_data == '0)
    `R5_ASSERT_IMP(a_finish_strobes, i_clk, i_rst_n, $fell(busy), o_valid)
    `R5_ASSERT_IMP(a_result_has_cause, i_clk, i_rst_n, o_valid, $past(busy) || $past(acc_query))

endmodule

bind raid5_block_read_with_rebuild_core r5brr_checker u_r5brr_checker (.*);
